### rtl/gkpg_pkg.sv
// ----------------------------------------------------------------------------
// gkpg_pkg
// Shared constants, types and constant functions for the Gabor kernel
// pixel generator.
// ----------------------------------------------------------------------------
package gkpg_pkg;

	localparam int MAX_SIZE         = 64;
	localparam int NUM_ORIENTATIONS = 64;
	localparam int NUM_PHASES       = 8;

	// register map
	localparam logic [1:0] REG_SIGMA  = 2'd0;
	localparam logic [1:0] REG_OMEGA  = 2'd1;
	localparam logic [1:0] REG_ORIENT = 2'd2;
	localparam logic [1:0] REG_PHASE  = 2'd3;

	localparam logic [10:0] SIGMA_RST  = 11'd256;
	localparam logic [14:0] OMEGA_RST  = 15'd4096;
	localparam logic [5:0]  ORIENT_RST = 6'd0;
	localparam logic [2:0]  PHASE_RST  = 3'd0;

	localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
	localparam logic [31:0] QUARTER    = 32'h4000_0000;
	localparam logic [30:0] SIN_A9     = 31'd172272;
	localparam logic [30:0] SIN_COEF [4] = '{31'd5026995, 31'd85569306, 31'd693598668,
		31'd1686629713};
	localparam logic [29:0] INV2PI_Q32 = 30'd683565276;
	localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
	localparam logic [29:0] LN2_Q30    = 30'd744261118;

	// pipeline latencies
	localparam int SIN_LAT = 6;
	localparam int DIV_QB  = 35;
	localparam int DIV_LAT = DIV_QB + 1;
	localparam int EXP_TERMS = 10;
	localparam int EXP_LAT = 2 * EXP_TERMS + 2;
	localparam int CAR_AT  = 8 + SIN_LAT;
	localparam int ENV_AT  = 3 + DIV_LAT + EXP_LAT;
	localparam int CAR_DLY = ENV_AT - CAR_AT;
	localparam int OUT_LAT = ENV_AT + 2;

	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} car_t;

	typedef struct packed {
		logic              big;
		logic [DIV_QB-1:0] quo;
	} quo_t;

	// sine of an angle in 2^-32 turn, signed q30, for constant tables
	function automatic logic signed [31:0] sine_q30_f(input logic [31:0] ang);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] v;
		z = {34'd0, ang[29:0]};
		if (ang[30]) begin
			z = 64'(Q30_ONE) - z;
		end
		z2 = (z * z) >> 30;
		p = 64'(SIN_A9);
		for (int i = 0; i < 4; i++) begin
			p = 64'(SIN_COEF[i]) - ((p * z2) >> 30);
		end
		v = (p * z) >> 30;
		return ang[31] ? -v[31:0] : v[31:0];
	endfunction

endpackage

### rtl/gkpg_sine.sv
// ----------------------------------------------------------------------------
// gkpg_sine
// Pipelined q30 sine: quarter-wave fold, then a degree 9 odd polynomial
// evaluated one Horner step per stage.
// ----------------------------------------------------------------------------
module gkpg_sine (
	input  logic          clk,
	input  logic [31:0]   ang,
	output gkpg_pkg::car_t res
);
	import gkpg_pkg::*;

	localparam int NS = SIN_LAT - 1;

	logic [30:0] z_s   [NS];
	logic [30:0] z2_s  [NS];
	logic [30:0] p_s   [NS];
	logic        sgn_s [NS];

	logic [30:0] zf;
	logic [61:0] zz;
	logic [61:0] pz;

	// fold into the first quarter
	always_comb begin
		zf = ang[30] ? (Q30_ONE - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
		zz = 62'(zf) * 62'(zf);
	end

	always_ff @(posedge clk) begin
		z_s[0]   <= zf;
		z2_s[0]  <= zz[60:30];
		p_s[0]   <= SIN_A9;
		sgn_s[0] <= ang[31];
	end

	for (genvar j = 1; j < NS; j++) begin : g_horner
		logic [61:0] pp;
		assign pp = 62'(p_s[j-1]) * 62'(z2_s[j-1]);
		always_ff @(posedge clk) begin
			p_s[j]   <= SIN_COEF[j-1] - pp[60:30];
			z_s[j]   <= z_s[j-1];
			z2_s[j]  <= z2_s[j-1];
			sgn_s[j] <= sgn_s[j-1];
		end
	end

	assign pz = 62'(p_s[NS-1]) * 62'(z_s[NS-1]);

	always_ff @(posedge clk) begin
		res.mag <= pz[61:30];
		res.neg <= sgn_s[NS-1];
	end

endmodule

### rtl/gkpg_div.sv
// ----------------------------------------------------------------------------
// gkpg_div
// Pipelined restoring divider for the gaussian exponent, one quotient bit
// per stage, with an overrange flag for quotients of 2^35 and above.
// ----------------------------------------------------------------------------
module gkpg_div (
	input  logic          clk,
	input  logic [58:0]   num,
	input  logic [21:0]   den,
	output gkpg_pkg::quo_t res
);
	import gkpg_pkg::*;

	logic [58:0]       rem_s [DIV_QB+1];
	logic [DIV_QB-1:0] q_s   [DIV_QB+1];
	logic              big_s [DIV_QB+1];

	logic [58:0] den_top;

	assign den_top = 59'(den) << DIV_QB;

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		q_s[0]   <= '0;
		big_s[0] <= (num >= den_top);
	end

	for (genvar j = 1; j <= DIV_QB; j++) begin : g_step
		localparam int SH = DIV_QB - j;
		logic [58:0] dsh;
		logic        ge;
		assign dsh = 59'(den) << SH;
		assign ge  = (rem_s[j-1] >= dsh);
		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? (rem_s[j-1] - dsh) : rem_s[j-1];
			q_s[j]   <= {q_s[j-1][DIV_QB-2:0], ge};
			big_s[j] <= big_s[j-1];
		end
	end

	assign res.big = big_s[DIV_QB];
	assign res.quo = q_s[DIV_QB];

endmodule

### rtl/gkpg_exp.sv
// ----------------------------------------------------------------------------
// gkpg_exp
// Gaussian envelope 2^-y in q30: exp(-f*ln2) by a nested order 10 series,
// two stages per term, then the integer part as a right shift.
// ----------------------------------------------------------------------------
module gkpg_exp (
	input  logic           clk,
	input  gkpg_pkg::quo_t yin,
	output logic [30:0]    env
);
	import gkpg_pkg::*;

	logic [29:0] w_s  [EXP_TERMS+1];
	logic [4:0]  k_s  [EXP_TERMS+1];
	logic        z_s  [EXP_TERMS+1];
	logic [30:0] q_s  [EXP_TERMS+1];
	logic [29:0] t_s  [EXP_TERMS];
	logic [29:0] wm_s [EXP_TERMS];
	logic [4:0]  km_s [EXP_TERMS];
	logic        zm_s [EXP_TERMS];

	logic [59:0] fl;

	assign fl = 60'(yin.quo[29:0]) * 60'(LN2_Q30);

	always_ff @(posedge clk) begin
		w_s[0] <= fl[59:30];
		k_s[0] <= yin.quo[34:30];
		z_s[0] <= yin.big | (yin.quo[34:30] == 5'd31);
		q_s[0] <= Q30_ONE;
	end

	for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
		localparam int N = EXP_TERMS - j;
		localparam int L = $clog2(N);
		localparam logic [30:0] M = 31'(((64'd1 << (30 + L)) + 64'(N) - 64'd1) / 64'(N));
		logic [60:0] wq;
		logic [60:0] tm;
		assign wq = 61'(w_s[j]) * 61'(q_s[j]);
		assign tm = 61'(t_s[j]) * 61'(M);
		always_ff @(posedge clk) begin
			t_s[j]    <= wq[59:30];
			wm_s[j]   <= w_s[j];
			km_s[j]   <= k_s[j];
			zm_s[j]   <= z_s[j];
			q_s[j+1]  <= Q30_ONE - 31'(tm >> (30 + L));
			w_s[j+1]  <= wm_s[j];
			k_s[j+1]  <= km_s[j];
			z_s[j+1]  <= zm_s[j];
		end
	end

	always_ff @(posedge clk) begin
		env <= z_s[EXP_TERMS] ? '0 : (q_s[EXP_TERMS] >> k_s[EXP_TERMS]);
	end

endmodule

### rtl/gabor_kernel_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// gabor_kernel_pixel_generator_unit
// Gabor kernel sample generator with an APB register port.
// ----------------------------------------------------------------------------
// One pixel coordinate is taken on every clock (busy stays low) and its q1.15
// kernel sample comes out at the end of the pipeline, marked by done
// for one cycle; results cannot be held off, so the consumer must take each
// one as it appears. The latency is set by the 36-stage exponent divider and
// the 22-stage envelope series pipeline. Registers may only be written while
// no pixel is in flight.
module gabor_kernel_pixel_generator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [5:0]         pixel_x,
	input  logic [5:0]         pixel_y,
	output logic               done,
	output logic signed [15:0] sample_value,
	output logic               outside_patch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import gkpg_pkg::*;

	logic [10:0] sigma_q;
	logic [14:0] omega_q;
	logic [5:0]  orient_q;
	logic [2:0]  phase_q;

	logic signed [31:0] cos_tab [64];
	logic signed [31:0] sin_tab [64];
	logic [31:0]        phq_tab [8];

	logic signed [31:0] cos_th_q;
	logic signed [31:0] sin_th_q;
	logic [31:0]        phq_q;
	logic [21:0]        sig2_q;

	// constant rotation and phase tables
	for (genvar i = 0; i < 64; i++) begin : g_rot
		localparam logic [31:0] THETA =
			32'((64'(i % NUM_ORIENTATIONS) << 31) / 64'(NUM_ORIENTATIONS));
		localparam logic signed [31:0] COS_V = sine_q30_f(THETA + QUARTER);
		localparam logic signed [31:0] SIN_V = sine_q30_f(THETA);
		assign cos_tab[i] = COS_V;
		assign sin_tab[i] = SIN_V;
	end

	for (genvar i = 0; i < 8; i++) begin : g_phase
		localparam logic [31:0] PHQ_V =
			32'((64'(i % NUM_PHASES) << 32) / 64'(NUM_PHASES) + 64'(QUARTER));
		assign phq_tab[i] = PHQ_V;
	end

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q  <= SIGMA_RST;
			omega_q  <= OMEGA_RST;
			orient_q <= ORIENT_RST;
			phase_q  <= PHASE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SIGMA:  sigma_q  <= pwdata[10:0];
				REG_OMEGA:  omega_q  <= pwdata[14:0];
				REG_ORIENT: orient_q <= pwdata[5:0];
				REG_PHASE:  phase_q  <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SIGMA:  prdata = 32'(sigma_q);
			REG_OMEGA:  prdata = 32'(omega_q);
			REG_ORIENT: prdata = 32'(orient_q);
			REG_PHASE:  prdata = 32'(phase_q);
			default:    prdata = '0;
		endcase
	end

	// derived static values, settled before an item reaches them
	always_ff @(posedge clk) begin
		cos_th_q <= cos_tab[orient_q];
		sin_th_q <= sin_tab[orient_q];
		phq_q    <= phq_tab[phase_q];
		sig2_q   <= 22'(sigma_q) * 22'(sigma_q);
	end

	assign busy = 1'b0;

	// stage 1: patch bounds and half-pixel offsets
	logic [6:0]        side;
	logic              acc;
	logic              vld_s1;
	logic              out_s1;
	logic signed [7:0] fx2_s1;
	logic signed [7:0] fy2_s1;
	logic [9:0]        fxw;
	logic [9:0]        fyw;

	assign acc  = start && !busy;
	assign side = 7'((12'(sigma_q) + 12'd16) >> 5);
	assign fxw  = {3'd0, pixel_x, 1'b0} - 10'(side) - 10'd1;
	assign fyw  = {3'd0, pixel_y, 1'b0} - 10'(side) - 10'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		out_s1 <= (9'(side) > 9'(MAX_SIZE)) || (7'(pixel_x) >= side) ||
			(7'(pixel_y) >= side);
		fx2_s1 <= fxw[7:0];
		fy2_s1 <= fyw[7:0];
	end

	// stage 2: rotation products, squared radius
	logic signed [39:0] pc_s2;
	logic signed [39:0] ps_s2;
	logic [14:0]        r2_s2;
	logic signed [15:0] fxx;
	logic signed [15:0] fyy;
	logic signed [15:0] rr;

	assign fxx = 16'(fx2_s1) * 16'(fx2_s1);
	assign fyy = 16'(fy2_s1) * 16'(fy2_s1);
	assign rr  = fxx + fyy;

	always_ff @(posedge clk) begin
		pc_s2 <= 40'(cos_th_q) * 40'(fx2_s1);
		ps_s2 <= 40'(sin_th_q) * 40'(fy2_s1);
		r2_s2 <= rr[14:0];
	end

	// stage 3: rotated offset, exponent numerator
	logic signed [39:0] dxq_s3;
	logic [45:0]        nl_s3;

	always_ff @(posedge clk) begin
		dxq_s3 <= pc_s2 - ps_s2;
		nl_s3  <= 46'(r2_s2) * 46'(LOG2E_Q30);
	end

	// stages 4 to 8: carrier angle
	logic        neg_s4;
	logic [38:0] adx_s4;
	logic        neg_s5;
	logic [33:0] mh_s5;
	logic [34:0] ml_s5;
	logic        neg_s6;
	logic [31:0] a_s6;
	logic        neg_s7;
	logic [61:0] t_s7;
	logic [31:0] ang_s8;
	logic [39:0] dxn;
	logic [53:0] mag;

	assign dxn = -dxq_s3;
	assign mag = {mh_s5, 20'd0} + 54'(ml_s5);

	always_ff @(posedge clk) begin
		neg_s4 <= dxq_s3[39];
		adx_s4 <= dxq_s3[39] ? dxn[38:0] : dxq_s3[38:0];
		neg_s5 <= neg_s4;
		mh_s5  <= 34'(omega_q) * 34'(adx_s4[38:20]);
		ml_s5  <= 35'(omega_q) * 35'(adx_s4[19:0]);
		neg_s6 <= neg_s5;
		a_s6   <= mag[53:22];
		neg_s7 <= neg_s6;
		t_s7   <= 62'(a_s6) * 62'(INV2PI_Q32);
		ang_s8 <= neg_s7 ? (phq_q - t_s7[52:21]) : (t_s7[52:21] + phq_q);
	end

	car_t car;
	quo_t quo;
	logic [30:0] env;

	gkpg_sine u_sine (
		.clk (clk),
		.ang (ang_s8),
		.res (car)
	);

	gkpg_div u_div (
		.clk (clk),
		.num ({nl_s3, 13'd0}),
		.den (sig2_q),
		.res (quo)
	);

	gkpg_exp u_exp (
		.clk (clk),
		.yin (quo),
		.env (env)
	);

	// align carrier and item tags with the envelope
	car_t car_q [CAR_DLY];
	logic vld_q [ENV_AT];
	logic out_q [ENV_AT];

	always_ff @(posedge clk) begin
		car_q[0] <= car;
		for (int i = 1; i < CAR_DLY; i++) begin
			car_q[i] <= car_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENV_AT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= vld_s1;
			for (int i = 1; i < ENV_AT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		out_q[0] <= out_s1;
		for (int i = 1; i < ENV_AT; i++) begin
			out_q[i] <= out_q[i-1];
		end
	end

	// product, rounding and saturation
	logic [61:0] prod_s62;
	logic        neg_s62;
	logic [61:0] rnd;
	logic [16:0] res;
	logic [16:0] resn;
	logic [16:0] resp;
	logic [16:0] negv;

	always_ff @(posedge clk) begin
		prod_s62 <= 62'(car_q[CAR_DLY-1].mag) * 62'(env);
		neg_s62  <= car_q[CAR_DLY-1].neg;
	end

	assign rnd  = prod_s62 + (62'd1 << 44);
	assign res  = rnd[61:45];
	assign resn = (res > 17'd32768) ? 17'd32768 : res;
	assign resp = (res > 17'd32767) ? 17'd32767 : res;
	assign negv = -resn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[ENV_AT-1];
		end
	end

	always_ff @(posedge clk) begin
		outside_patch <= out_q[ENV_AT-1];
		if (out_q[ENV_AT-1]) begin
			sample_value <= '0;
		end else if (neg_s62) begin
			sample_value <= negv[15:0];
		end else begin
			sample_value <= resp[15:0];
		end
	end

endmodule

### rtl/gkpg_chk.sv
// ----------------------------------------------------------------------------
// gkpg_chk
// Port-level checks for the Gabor kernel pixel generator, bound to the top.
// ----------------------------------------------------------------------------
module gkpg_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] sample_value,
	input logic               outside_patch
);
	import gkpg_pkg::*;

	// every result comes from a transfer a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, OUT_LAT))
		else $error("result without matching start transfer");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && outside_patch) |-> (sample_value == 16'sd0))
		else $error("outside pixel with nonzero sample");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind gabor_kernel_pixel_generator_unit gkpg_chk u_chk (.*);
